FILE: rtl/core/rce_pkg.sv
`default_nettype none

package rce_pkg;

	// Node index: client + depot_count fits in nine bits
	localparam int NODE_W = 9;
	localparam int OUT_W  = 48;

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_VISIT = 1'b1;

	// Read address selects for the cost table
	localparam logic [1:0] RD_VISIT = 2'd0;
	localparam logic [1:0] RD_OUT   = 2'd1;
	localparam logic [1:0] RD_BACK  = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] cost_value;
		logic [7:0]  client;
		logic        visited;
		logic [7:0]  depot;
		logic        route_last;
		logic        tour_last;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] route_cost;
		logic [OUT_W-1:0] total_cost;
		logic             total_done;
		logic             range_error;
	} result_t;

	typedef struct packed {
		logic       wr;      // table write transaction accepted
		logic       visit;   // visit transaction accepted
		logic [1:0] rd_sel;  // table read address select
		logic       acc;     // add the leg read last cycle
		logic       emit;    // load result register, close route
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic need_leg;
		logic active_after;
		logic in_route_last;
		logic route_last_q;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/rce_ram.sv
`default_nettype none

module rce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/rce_ctrl.sv
`default_nettype none

module rce_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	input  wire rce_pkg::status_t status,
	output rce_pkg::cmd_t         cmd
);

	import rce_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_VACC     = 3'd1;
	localparam logic [2:0] S_RD_OUT   = 3'd2;
	localparam logic [2:0] S_ACC_OUT  = 3'd3;
	localparam logic [2:0] S_ACC_BACK = 3'd4;
	localparam logic [2:0] S_EMIT     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       can_load;
	logic       accept;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign can_load     = !out_valid_q || result_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.rd_sel = RD_VISIT;
				if (accept) begin
					if (status.is_write) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.visit = 1'b1;
						if (status.need_leg) begin
							state_d = S_VACC;
						end else if (status.in_route_last) begin
							state_d = status.active_after ? S_RD_OUT : S_EMIT;
						end
					end
				end
			end
			S_VACC: begin
				cmd.acc = 1'b1;
				state_d = status.route_last_q ? S_RD_OUT : S_IDLE;
			end
			S_RD_OUT: begin
				cmd.rd_sel = RD_OUT;
				state_d    = S_ACC_OUT;
			end
			S_ACC_OUT: begin
				cmd.acc    = 1'b1;
				cmd.rd_sel = RD_BACK;
				state_d    = S_ACC_BACK;
			end
			S_ACC_BACK: begin
				cmd.acc = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (can_load) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_vacc_after_visit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VACC) |-> $past(accept && !status.is_write))
		else $error("leg accumulate without a preceding visit");

	a_back_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC_BACK) |-> ($past(state_q) == S_ACC_OUT))
		else $error("return leg out of sequence");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result not presented after emit");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !can_load) |=> (state_q == S_EMIT))
		else $error("left emit while result register busy");

endmodule

`default_nettype wire

FILE: rtl/core/rce_datapath.sv
`default_nettype none

module rce_datapath #(
	parameter int MAX_NODES = 256,
	parameter int COST_BITS = 32,
	parameter int SUM_BITS  = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [7:0]       cfg_wr_data,
	input  wire rce_pkg::item_t   item,
	input  wire rce_pkg::cmd_t    cmd,
	output rce_pkg::status_t      status,
	output rce_pkg::result_t      result
);

	import rce_pkg::*;

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int ACC_W  = (SUM_BITS > COST_BITS ? SUM_BITS : COST_BITS) + 1;
	localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'({SUM_BITS{1'b1}});

	function automatic logic [IDX_W-1:0] to_idx(input logic [NODE_W-1:0] n);
		logic [NODE_W+IDX_W-1:0] w;
		w = (NODE_W + IDX_W)'(n);
		return w[IDX_W-1:0];
	endfunction

	function automatic logic in_range(input logic [NODE_W-1:0] n);
		return 32'(n) < MAX_NODES;
	endfunction

	function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] s;
		s = ACC_W'(a) + b;
		if (s > SUM_MAX) begin
			return {SUM_BITS{1'b1}};
		end
		return s[SUM_BITS-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input logic [SUM_BITS-1:0] v);
		logic [SUM_BITS+OUT_W-1:0] w;
		w = (SUM_BITS + OUT_W)'(v);
		return w[OUT_W-1:0];
	endfunction

	logic [7:0]          depot_count_q;
	logic [7:0]          prev_q;
	logic [7:0]          first_q;
	logic                active_q;
	logic [SUM_BITS-1:0] route_q;
	logic [SUM_BITS-1:0] total_q;
	logic                err_q;
	logic                leg_ok_q;
	logic [7:0]          depot_q;
	logic                route_last_q;
	logic                tour_last_q;
	result_t             result_q;

	logic [NODE_W-1:0]   from_node;
	logic [NODE_W-1:0]   to_node;
	logic [NODE_W-1:0]   dc_ext;
	logic [ADDR_W-1:0]   raddr;
	logic [ADDR_W-1:0]   waddr;
	logic                wr_ok;
	logic [COST_BITS-1:0] rdata;
	logic [ACC_W-1:0]    leg;
	logic [SUM_BITS-1:0] total_new;

	assign dc_ext = NODE_W'(depot_count_q);

	// Table read address
	always_comb begin
		case (cmd.rd_sel)
			RD_OUT: begin
				from_node = NODE_W'(depot_q);
				to_node   = NODE_W'(first_q) + dc_ext;
			end
			RD_BACK: begin
				from_node = NODE_W'(prev_q) + dc_ext;
				to_node   = NODE_W'(depot_q);
			end
			default: begin
				from_node = NODE_W'(prev_q) + dc_ext;
				to_node   = NODE_W'(item.client) + dc_ext;
			end
		endcase
	end

	assign raddr = {to_idx(from_node), to_idx(to_node)};
	assign waddr = {to_idx(NODE_W'(item.row)), to_idx(NODE_W'(item.col))};
	assign wr_ok = cmd.wr && in_range(NODE_W'(item.row)) && in_range(NODE_W'(item.col));

	rce_ram #(
		.WIDTH (COST_BITS),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (waddr),
		.wdata (item.cost_value[COST_BITS-1:0]),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign leg       = leg_ok_q ? ACC_W'(rdata) : '0;
	assign total_new = sat_add(total_q, ACC_W'(route_q));

	always_comb begin
		status.is_write      = (item.kind == KIND_WRITE);
		status.need_leg      = (item.kind == KIND_VISIT) && item.visited && active_q;
		status.active_after  = active_q || item.visited;
		status.in_route_last = item.route_last;
		status.route_last_q  = route_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depot_count_q <= 8'd1;
			prev_q        <= '0;
			first_q       <= '0;
			active_q      <= 1'b0;
			route_q       <= '0;
			total_q       <= '0;
			err_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				depot_count_q <= cfg_wr_data;
			end
			if (cmd.visit && item.visited) begin
				if (!active_q) begin
					first_q <= item.client;
				end
				prev_q   <= item.client;
				active_q <= 1'b1;
			end
			if (cmd.acc) begin
				route_q <= sat_add(route_q, leg);
				if (!leg_ok_q) begin
					err_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				route_q  <= '0;
				active_q <= 1'b0;
				err_q    <= 1'b0;
				total_q  <= tour_last_q ? '0 : total_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		leg_ok_q <= in_range(from_node) && in_range(to_node);
		if (cmd.visit) begin
			depot_q      <= item.depot;
			route_last_q <= item.route_last;
			tour_last_q  <= item.tour_last;
		end
		if (cmd.emit) begin
			result_q.route_cost  <= to_out(route_q);
			result_q.total_cost  <= to_out(total_new);
			result_q.total_done  <= tour_last_q;
			result_q.range_error <= err_q;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: rtl/core/route_cost_evaluator_top.sv
`default_nettype none

// Route cost evaluator. Load the cost table first with write transactions
// (kind = 0, row/col/cost_value), then stream route visits (kind = 1) in
// permutation order. Client nodes sit at client + depot_count in the table;
// depot nodes at their own number. A served visit adds the leg from the
// previously served client; the last position of a route adds the
// depot-to-first and last-to-depot legs and produces one result transaction
// with the saturated route cost, the running individual total, the tour-end
// flag and a range error flag for any node index at or beyond MAX_NODES
// (such legs add zero). A route with no served client costs zero. Writes
// with row or col out of range are dropped. A served client after another
// of the same route adds a leg step; a route end reads the depot-to-first
// leg, adds it while reading the last-to-depot leg, adds that and loads
// the result, or only loads the result if no client was served.
// The table has a single read port with registered read, so every leg
// is read before it is summed. The input stays open while a result
// waits; the sequencer only stalls at the result load if the previous
// result has not been taken. The user must write depot_count only while
// the block is idle; this is not enforced. The table holds no reset
// contents: reading a never-written entry gives an unspecified cost.
module route_cost_evaluator_top #(
	parameter int MAX_NODES = 256,
	parameter int COST_BITS = 32,
	parameter int SUM_BITS  = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [7:0]       cfg_wr_data,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire rce_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output rce_pkg::result_t      result
);

	import rce_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer: handshakes and leg ordering
	rce_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Cost table, route/total accumulators, result register
	rce_datapath #(
		.MAX_NODES (MAX_NODES),
		.COST_BITS (COST_BITS),
		.SUM_BITS  (SUM_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result      (result)
	);

endmodule

`default_nettype wire

FILE: verif/route_cost_evaluator_top_tb.sv
`timescale 1ns / 1ps

// Predicts the route cost results and holds the ones not yet seen on the output.
class route_cost_board;
	localparam int NODES = 256;
	localparam logic [47:0] SUM_CEIL = '1;

	logic [31:0] cost_tab [NODES*NODES];
	logic [7:0] depot_cnt;
	logic [7:0] prev_client;
	logic [7:0] first_client;
	logic route_open;
	logic [47:0] route_acc;
	logic [47:0] tour_acc;
	logic route_fault;
	rce_pkg::result_t pending[$];
	int fails;

	function new();
		depot_cnt = 8'd1;
		prev_client = '0;
		first_client = '0;
		route_open = 1'b0;
		route_acc = '0;
		tour_acc = '0;
		route_fault = 1'b0;
		fails = 0;
	endfunction

	function int waiting();
		return pending.size();
	endfunction

	function logic [47:0] sum_sat(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? SUM_CEIL : s[47:0];
	endfunction

	// out-of-range node: no table read, adds zero, flags the route
	function logic [47:0] leg_cost(int unsigned from, int unsigned to);
		if (from >= NODES || to >= NODES) begin
			route_fault = 1'b1;
			return '0;
		end
		return {16'h0, cost_tab[from * NODES + to]};
	endfunction

	function void take_item(rce_pkg::item_t it);
		rce_pkg::result_t exp;
		if (it.kind == rce_pkg::KIND_WRITE) begin
			cost_tab[int'(it.row) * NODES + int'(it.col)] = it.cost_value;
			return;
		end
		if (it.visited) begin
			if (route_open)
				route_acc = sum_sat(route_acc, leg_cost(int'(prev_client) + int'(depot_cnt),
					int'(it.client) + int'(depot_cnt)));
			else
				first_client = it.client;
			prev_client = it.client;
			route_open = 1'b1;
		end
		if (!it.route_last)
			return;
		if (route_open) begin
			route_acc = sum_sat(route_acc, leg_cost(int'(it.depot),
				int'(first_client) + int'(depot_cnt)));
			route_acc = sum_sat(route_acc, leg_cost(int'(prev_client) + int'(depot_cnt),
				int'(it.depot)));
		end
		tour_acc = sum_sat(tour_acc, route_acc);
		exp.route_cost = route_acc;
		exp.total_cost = tour_acc;
		exp.total_done = it.tour_last;
		exp.range_error = route_fault;
		pending.push_back(exp);
		route_acc = '0;
		route_open = 1'b0;
		route_fault = 1'b0;
		if (it.tour_last)
			tour_acc = '0;
	endfunction

	function void match_result(rce_pkg::result_t r);
		rce_pkg::result_t exp;
		if (pending.size() == 0) begin
			$error("unexpected result: route_cost %0h total_cost %0h", r.route_cost,
				r.total_cost);
			fails++;
			return;
		end
		exp = pending.pop_front();
		if (r.route_cost !== exp.route_cost) begin
			$error("route_cost: expected %0h actual %0h", exp.route_cost, r.route_cost);
			fails++;
		end
		if (r.total_cost !== exp.total_cost) begin
			$error("total_cost: expected %0h actual %0h", exp.total_cost, r.total_cost);
			fails++;
		end
		if (r.total_done !== exp.total_done) begin
			$error("total_done: expected %0b actual %0b", exp.total_done, r.total_done);
			fails++;
		end
		if (r.range_error !== exp.range_error) begin
			$error("range_error: expected %0b actual %0b", exp.range_error, r.range_error);
			fails++;
		end
	endfunction
endclass

module route_cost_evaluator_top_tb;
	// route end is the slowest step; leave margin
	localparam int SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	rce_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	rce_pkg::result_t result;

	// idle rates in percent per cycle, and a long receiver hold-off
	int tx_idle = 0;
	int rx_idle = 0;
	int rx_hold = 0;

	// depots and clients of the current random phase; their table entries are written
	logic [7:0] depot_pool [3];
	logic [7:0] client_pool [5];

	route_cost_board board;

	route_cost_evaluator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Fields that do not matter for an item's kind still get random values,
	// so every input bit toggles.
	function automatic rce_pkg::item_t rand_fields();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(rce_pkg::item_t)-1:0];
	endfunction

	function automatic rce_pkg::item_t table_item(int r, int c, logic [31:0] cost);
		rce_pkg::item_t it;
		it = rand_fields();
		it.kind = rce_pkg::KIND_WRITE;
		it.row = 8'(r);
		it.col = 8'(c);
		it.cost_value = cost;
		return it;
	endfunction

	function automatic rce_pkg::item_t visit_item(logic [7:0] cl, logic vis, logic [7:0] dep,
		logic rl, logic tl);
		rce_pkg::item_t it;
		it = rand_fields();
		it.kind = rce_pkg::KIND_VISIT;
		it.client = cl;
		it.visited = vis;
		it.depot = dep;
		it.route_last = rl;
		it.tour_last = tl;
		return it;
	endfunction

	// Costs lean on the extremes so that large sums show up in the random part.
	function automatic logic [31:0] pick_cost();
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			2: return 32'($urandom_range(255));
			default: return $urandom;
		endcase
	endfunction

	// Mostly clients from the phase's pool; now and then a client whose node
	// lands past the end of the table.
	function automatic logic [7:0] pick_client();
		int dc;
		dc = int'(board.depot_cnt);
		if (dc > 0 && $urandom_range(9) == 0)
			return 8'(256 - dc + int'($urandom_range(dc - 1)));
		return client_pool[$urandom_range(4)];
	endfunction

	// Offer one transaction and hold it until accepted. Valid only drops when
	// the sender decides to idle, so back-to-back transactions keep it high.
	task automatic send_item(input rce_pkg::item_t it);
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		board.take_item(it);
	endtask

	// Block is idle once every expected result is in and the tail has passed;
	// only then may depot_count change.
	task automatic finish_phase();
		item_valid <= 1'b0;
		while (board.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_depot_count(input logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.depot_cnt = v;
	endtask

	// Every ordered pair among the given nodes, so no later leg reads an
	// unwritten entry.
	task automatic write_pairs(input int nodes[8]);
		for (int a = 0; a < 8; a++)
			for (int b = 0; b < 8; b++)
				send_item(table_item(nodes[a], nodes[b], pick_cost()));
	endtask

	// One individual: a few routes of a few positions. Noise: stray table
	// writes, tour_last on inner positions, routes with nothing served.
	task automatic send_tour(inout int count);
		int routes;
		int len;
		logic [7:0] dep;
		logic none_served;
		logic last;
		routes = $urandom_range(1, 4);
		for (int r = 0; r < routes; r++) begin
			dep = depot_pool[$urandom_range(2)];
			len = $urandom_range(1, 7);
			none_served = ($urandom_range(9) == 0);
			for (int p = 0; p < len; p++) begin
				if ($urandom_range(11) == 0)
					send_item(table_item($urandom_range(255), $urandom_range(255), pick_cost()));
				last = (p == len - 1);
				send_item(visit_item(pick_client(),
					none_served ? 1'b0 : 1'($urandom_range(3) != 0), dep, last,
					last ? 1'(r == routes - 1) : 1'($urandom_range(1))));
				count++;
			end
		end
	endtask

	task automatic random_phase(input int items);
		int count;
		int nodes[8];
		for (int k = 0; k < 3; k++) begin
			depot_pool[k] = 8'($urandom_range(255));
			nodes[k] = int'(depot_pool[k]);
		end
		for (int k = 0; k < 5; k++) begin
			client_pool[k] = 8'($urandom_range(255 - int'(board.depot_cnt)));
			nodes[3 + k] = int'(client_pool[k]) + int'(board.depot_cnt);
		end
		write_pairs(nodes);
		count = 0;
		while (count < items)
			send_tour(count);
		finish_phase();
	endtask

	// Result side: check every accepted transaction, then pick next cycle's ready.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				board.match_result(result);
			if (rx_hold > 0) begin
				result_ready <= 1'b0;
				rx_hold--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every node that the directed checks read goes into the table first.
		set_depot_count(8'd1);
		write_pairs('{0, 4, 5, 6, 21, 22, 128, 255});
		finish_phase();

		tx_idle = 14;
		rx_idle = 64;

		// Directed, depot_count = 1.
		send_item(table_item(0, 5, '1));
		send_item(table_item(5, 0, '0));
		// single served client: depot legs only
		send_item(visit_item(8'd4, 1'b1, 8'd0, 1'b1, 1'b0));
		// unserved position carrying tour_last, which is ignored off the route end
		send_item(visit_item(8'd7, 1'b0, 8'd255, 1'b0, 1'b1));
		// client 254 is node 255, the last one in the table
		send_item(visit_item(8'd254, 1'b1, 8'd255, 1'b0, 1'b0));
		send_item(visit_item(8'd3, 1'b1, 8'd255, 1'b1, 1'b0));
		// no served client: zero cost, no depot legs
		send_item(visit_item(8'd9, 1'b0, 8'd17, 1'b1, 1'b0));
		// client 255 is node 256: both depot legs out of range
		send_item(visit_item(8'd255, 1'b1, 8'd1, 1'b1, 1'b0));
		// out-of-range client in the middle of a route
		send_item(visit_item(8'd20, 1'b1, 8'd6, 1'b0, 1'b0));
		send_item(visit_item(8'd255, 1'b1, 8'd6, 1'b0, 1'b0));
		send_item(visit_item(8'd21, 1'b1, 8'd6, 1'b1, 1'b1));
		// a table write with route_last set still gives no result
		begin
			rce_pkg::item_t wr;
			wr = table_item(200, 201, '1);
			wr.route_last = 1'b1;
			wr.tour_last = 1'b1;
			send_item(wr);
		end
		finish_phase();

		// Zero depot_count: client node equals client number.
		set_depot_count(8'd0);
		send_item(visit_item(8'd255, 1'b1, 8'd0, 1'b0, 1'b0));
		send_item(visit_item(8'd0, 1'b1, 8'd0, 1'b1, 1'b1));
		finish_phase();

		// Largest depot_count: only client 0 stays in range.
		set_depot_count(8'd255);
		send_item(visit_item(8'd0, 1'b1, 8'd128, 1'b0, 1'b0));
		send_item(visit_item(8'd0, 1'b1, 8'd128, 1'b1, 1'b0));
		send_item(visit_item(8'd1, 1'b1, 8'd3, 1'b1, 1'b1));
		finish_phase();

		// Random part, three idling profiles.
		tx_idle = 14;
		rx_idle = 64;
		set_depot_count(8'($urandom_range(1, 255)));
		random_phase(300);

		tx_idle = 64;
		rx_idle = 14;
		set_depot_count(8'($urandom_range(0, 8)));
		random_phase(300);

		// No idling; the receiver holds off for a long stretch at the start so
		// results pile up and the input stalls.
		tx_idle = 0;
		rx_idle = 0;
		set_depot_count(8'($urandom_range(1, 255)));
		rx_hold = 400;
		random_phase(300);

		if (board.fails == 0 && board.waiting() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog, many times the longest correct run.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/rce_pkg.sv
rtl/core/rce_ram.sv
rtl/core/rce_ctrl.sv
rtl/core/rce_datapath.sv
rtl/core/route_cost_evaluator_top.sv
verif/route_cost_evaluator_top_tb.sv
